// File: design/byte_stuff_framer_xor_trailer_macros.svh
`ifndef BYTE_STUFF_FRAMER_XOR_TRAILER_MACROS_SVH
`define BYTE_STUFF_FRAMER_XOR_TRAILER_MACROS_SVH

// Concurrent check that is suspended while reset is high.
`define BSF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Concurrent check that also holds during reset.
`define BSF_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/bsf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bsf_pkg;

  localparam logic [7:0] FLAG_BYTE = 8'h24;
  localparam logic [7:0] ESC_BYTE  = 8'h2F;

  // Largest number of results that one item can cause.
  localparam int MAX_RES = 5;
  localparam int IDX_W   = $clog2(MAX_RES + 1);

  // One item expanded into its result bytes.
  typedef struct packed {
    logic [MAX_RES-1:0][7:0] bytes;
    logic [IDX_W-1:0]        count;
    logic                    has_trailer;
  } frame_t;

endpackage

`default_nettype wire

// File: design/bsf_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface bsf_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_byte;
  logic       last_byte;
  logic       flip_first;

  modport source (output valid, data_byte, first_byte, last_byte, flip_first, input ready);
  modport sink (input valid, data_byte, first_byte, last_byte, flip_first, output ready);
endinterface

interface bsf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       is_trailer;
  logic       run_end;

  modport source (output valid, out_byte, is_trailer, run_end, input ready);
  modport sink (input valid, out_byte, is_trailer, run_end, output ready);
endinterface

`default_nettype wire

// File: design/bsf_expand.sv
`timescale 1ns / 1ps
`default_nettype none

module bsf_expand (
  input  wire logic [7:0]    data_byte,
  input  wire logic          first_byte,
  input  wire logic          last_byte,
  input  wire logic          flip_first,
  input  wire logic [7:0]    parity_in,
  output bsf_pkg::frame_t    frame,
  output logic [7:0]         parity_out
);
  import bsf_pkg::*;

  logic             esc;
  logic [7:0]       base;
  logic [7:0]       par;
  logic [7:0]       inner;
  logic [IDX_W-1:0] pos;

  assign esc = (data_byte == FLAG_BYTE) || (data_byte == ESC_BYTE);

  always_comb begin
    base  = first_byte ? 8'h00 : parity_in;
    par   = base ^ data_byte ^ (esc ? ESC_BYTE : 8'h00);
    inner = esc ? ESC_BYTE : data_byte;
    pos   = '0;
    frame = '0;

    if (first_byte) begin
      frame.bytes[pos] = FLAG_BYTE;
      pos = pos + 1'b1;
    end

    // The error injection touches only the first byte after the flag;
    // the parity was already formed from the unflipped value.
    frame.bytes[pos] = {inner[7:1], inner[0] ^ (first_byte & flip_first)};
    pos = pos + 1'b1;

    if (esc) begin
      frame.bytes[pos] = data_byte;
      pos = pos + 1'b1;
    end

    if (last_byte) begin
      frame.bytes[pos] = FLAG_BYTE;
      frame.bytes[pos + 1'b1] = par;
      pos = pos + 2'd2;
    end

    frame.count       = pos;
    frame.has_trailer = last_byte;
    parity_out        = par;
  end

endmodule

`default_nettype wire

// File: design/bsf_emit.sv
`timescale 1ns / 1ps
`default_nettype none

module bsf_emit (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       load,
  input  bsf_pkg::frame_t frame_in,
  output logic            load_ready,
  bsf_out_if.source       dout
);
  import bsf_pkg::*;

  frame_t           frame;
  logic             busy;
  logic [IDX_W-1:0] idx;
  logic             adv;
  logic             last_slot;

  assign adv        = busy && (!dout.valid || dout.ready);
  assign last_slot  = (idx == frame.count - 1'b1);
  assign load_ready = !busy || (adv && last_slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= '0;
    end else if (load) begin
      busy <= 1'b1;
      idx  <= '0;
    end else if (adv && last_slot) begin
      busy <= 1'b0;
    end else if (adv) begin
      idx <= idx + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame <= frame_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dout.valid <= 1'b0;
    end else if (adv) begin
      dout.valid <= 1'b1;
    end else if (dout.ready) begin
      dout.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dout.out_byte   <= frame.bytes[idx];
      dout.is_trailer <= last_slot && frame.has_trailer;
      dout.run_end    <= last_slot;
    end
  end

endmodule

`default_nettype wire

// File: design/byte_stuff_framer_xor_trailer.sv
// Byte-stuffing framer with an XOR parity trailer.
// Channel din takes one payload byte per item with first_byte, last_byte
// and flip_first marks; channel dout gives the framed stream, one byte per
// item, with is_trailer on the parity byte and run_end on the final byte
// caused by each input item. Both channels move an item at a rising edge
// where valid and ready are high.
// An input item causes one to five output items. The first of them goes
// through the expansion register and then the output register to dout;
// the rest follow one per cycle while dout.ready stays high. The next
// input item is taken in the cycle its predecessor's last byte moves into
// the output register, so the block sustains one output byte per cycle
// while dout.ready stays high: an item gives one output byte for a plain
// inner byte and up to five for a one-byte frame whose byte needs an
// escape. The one-byte output port sets this rate.
// When the receiver stalls, the output register holds its byte and din
// stops taking items while the expansion register holds an item.
// Reset (rst, synchronous) drops dout.valid, empties the expansion
// register and clears the running parity to zero.
`timescale 1ns / 1ps
`default_nettype none

module byte_stuff_framer_xor_trailer (
  input wire logic  clk,
  input wire logic  rst,
  bsf_in_if.sink    din,
  bsf_out_if.source dout
);
  import bsf_pkg::*;

  // Running parity carried from one item to the next.
  logic [7:0] parity;
  logic [7:0] parity_next;
  frame_t     frame_new;
  logic       load_ready;
  logic       load;

  assign din.ready = load_ready;
  assign load      = din.valid && load_ready;

  // Expansion of the incoming item into its flag, escape, data and trailer
  // bytes; the parity for the next item comes out of the same logic.
  bsf_expand u_expand (
    .data_byte  (din.data_byte),
    .first_byte (din.first_byte),
    .last_byte  (din.last_byte),
    .flip_first (din.flip_first),
    .parity_in  (parity),
    .frame      (frame_new),
    .parity_out (parity_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      parity <= 8'h00;
    end else if (load) begin
      parity <= parity_next;
    end
  end

  // Holds the expanded item and walks it out through the output register.
  bsf_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .load       (load),
    .frame_in   (frame_new),
    .load_ready (load_ready),
    .dout       (dout)
  );

endmodule

`default_nettype wire

// File: design/bsf_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "byte_stuff_framer_xor_trailer_macros.svh"

module bsf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_byte,
  input wire logic       out_is_trailer,
  input wire logic       out_run_end
);
  import bsf_pkg::*;

  logic [7:0] prev_byte;
  logic       trailer_seen;
  logic       trailer_take;

  assign trailer_seen = out_valid && out_is_trailer;
  assign trailer_take = trailer_seen && out_ready;

  // Last byte delivered on the output channel.
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte <= 8'h00;
    end else if (out_valid && out_ready) begin
      prev_byte <= out_byte;
    end
  end

  `BSF_ASSERT_ALWAYS(a_reset_idle, rst |=> !out_valid, "output valid after reset")
  `BSF_ASSERT(a_hold, out_valid && !out_ready |=> out_valid, "output item dropped while stalled")
  `BSF_ASSERT(a_trailer_ends, trailer_seen |-> out_run_end, "trailer is not the final byte")
  `BSF_ASSERT(a_flag_before_trailer, trailer_take |-> prev_byte == FLAG_BYTE, "trailer without flag")

endmodule

bind byte_stuff_framer_xor_trailer bsf_checker u_checker (
  .clk            (clk),
  .rst            (rst),
  .out_valid      (dout.valid),
  .out_ready      (dout.ready),
  .out_byte       (dout.out_byte),
  .out_is_trailer (dout.is_trailer),
  .out_run_end    (dout.run_end)
);

`default_nettype wire
